@@ hdl/sorted_alarm_queue_timer_top_macros.svh @@
// Assertion macros for the sorted alarm queue timer.
// Used by sorted_alarm_queue_timer_top; no other dependencies.
`ifndef SORTED_ALARM_QUEUE_TIMER_TOP_MACROS_SVH
`define SORTED_ALARM_QUEUE_TIMER_TOP_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define SAQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequence holds in the cycle after the antecedent.
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/saqt_pkg.sv @@
// Shared types and codes for the sorted alarm queue timer.
// No dependencies.
package saqt_pkg;
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_FIRE,
        ST_EMIT
    } eng_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  alarm_slot;
        logic [31:0] deadline;
    } saqt_req_t;
endpackage

@@ hdl/saqt_fifo.sv @@
// Short request queue between the front and the engine.
// Depends on saqt_pkg.
module saqt_fifo
    import saqt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  saqt_req_t in_req,
    output logic      out_valid,
    input  logic      out_pop,
    output saqt_req_t out_req
);
    saqt_req_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (out_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, out_pop};
        end
    end
endmodule

@@ hdl/saqt_front.sv @@
// Front part: accept requests, classify them and mask the fields.
// Depends on saqt_pkg.
module saqt_front
    import saqt_pkg::*;
#(
    parameter int ALARM_SLOTS = 16,
    parameter int TICK_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [1:0]  action,
    input  logic [3:0]  alarm_slot,
    input  logic [31:0] deadline,
    output logic        q_valid,
    input  logic        q_stall,
    output saqt_req_t   q_req
);
    saqt_req_t  req_reg;
    logic       full_reg;
    logic       take;
    logic [1:0] act_cls;
    logic [31:0] dl_m;

    assign stall_in = full_reg && q_stall;
    assign take     = valid_in && !stall_in;
    assign q_valid  = full_reg;
    assign q_req    = req_reg;

    always_comb
    begin
        dl_m = deadline;
        if (TICK_BITS < 32)
        begin
            dl_m = deadline & ((32'd1 << TICK_BITS) - 32'd1);
        end
        act_cls = action;
        // out-of-range slot or unknown code: acknowledge only
        if ((action == ACT_SET || action == ACT_CANCEL) && 32'(alarm_slot) >= ALARM_SLOTS)
        begin
            act_cls = ACT_NONE;
        end
        // zero deadline cancels
        if (action == ACT_SET && dl_m == 32'd0)
        begin
            act_cls = ACT_CANCEL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= '{act_cls, alarm_slot, dl_m};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (take)
        begin
            full_reg <= 1'b1;
        end
        else if (!q_stall)
        begin
            full_reg <= 1'b0;
        end
    end
endmodule

@@ hdl/saqt_engine.sv @@
// Back part: sorted list kept in registers, walked one position a cycle.
// Depends on saqt_pkg.
module saqt_engine
    import saqt_pkg::*;
#(
    parameter int ALARM_SLOTS = 16,
    parameter int TICK_BITS   = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TICK_BITS-1:0] cfg_tick,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  saqt_req_t            q_req,
    output logic                 valid_out,
    input  logic                 stall_out,
    output logic [1:0]           result_kind,
    output logic [3:0]           fired_slot,
    output logic [31:0]          tick_value,
    output logic                 reschedule,
    output logic                 last
);
    localparam int SB = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int LB = $clog2(ALARM_SLOTS + 1);

    eng_state_t st_reg, st_next;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] dl_reg [ALARM_SLOTS];
    logic [SB-1:0]        ord_reg [ALARM_SLOTS];
    logic [ALARM_SLOTS-1:0] queued_reg;
    logic [LB-1:0] len_reg;
    logic [LB-1:0] pos_reg;
    logic          found_reg;
    logic          fired_reg;
    saqt_req_t     cur_reg;
    logic          ov_reg;
    logic [1:0]    ok_reg;
    logic [3:0]    os_reg;
    logic [31:0]   ot_reg;
    logic          or_reg, ol_reg;
    logic          out_free;
    logic [SB-1:0] slot_i;
    logic [SB-1:0] head;
    logic [TICK_BITS-1:0] cdl;
    logic [TICK_BITS-1:0] tick_inc;

    assign out_free = !ov_reg || !stall_out;
    assign slot_i   = SB'(cur_reg.alarm_slot);
    assign head     = ord_reg[0];
    assign cdl      = TICK_BITS'(cur_reg.deadline);
    assign tick_inc = tick_reg + 1'b1;

    assign valid_out   = ov_reg;
    assign result_kind = ok_reg;
    assign fired_slot  = os_reg;
    assign tick_value  = ot_reg;
    assign reschedule  = or_reg;
    assign last        = ol_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && !cfg_we)
                begin
                    if (q_req.action == ACT_TICK)
                    begin
                        st_next = ST_FIRE;
                    end
                    else if (q_req.action == ACT_SET || q_req.action == ACT_CANCEL)
                    begin
                        st_next = ST_REMOVE;
                    end
                    else
                    begin
                        st_next = ST_EMIT;
                    end
                end
            end
            ST_REMOVE:
            begin
                if (pos_reg >= len_reg || !queued_reg[slot_i])
                begin
                    st_next = (cur_reg.action == ACT_SET) ? ST_INSERT : ST_EMIT;
                end
            end
            ST_INSERT:
            begin
                if (pos_reg >= len_reg || dl_reg[ord_reg[pos_reg[SB-1:0]]] > cdl)
                begin
                    st_next = ST_EMIT;
                end
            end
            ST_FIRE:
            begin
                if (len_reg == '0 || dl_reg[head] > tick_reg)
                begin
                    if (out_free)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign q_pop = (st_reg == ST_IDLE) && q_valid && !cfg_we;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_req;
        end
        if (st_reg == ST_INSERT && (pos_reg >= len_reg || dl_reg[ord_reg[pos_reg[SB-1:0]]] > cdl))
        begin
            dl_reg[slot_i] <= cdl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            tick_reg   <= '0;
            queued_reg <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            fired_reg  <= 1'b0;
            ov_reg     <= 1'b0;
            ok_reg     <= KIND_ACK;
            os_reg     <= '0;
            ot_reg     <= '0;
            or_reg     <= 1'b0;
            ol_reg     <= 1'b0;
            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                ord_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            // drop an accepted result unless a new one replaces it
            if (ov_reg && !stall_out && st_reg != ST_FIRE && st_reg != ST_EMIT)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                tick_reg   <= cfg_tick;
                queued_reg <= '0;
                len_reg    <= '0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    pos_reg   <= '0;
                    found_reg <= 1'b0;
                    fired_reg <= 1'b0;
                    if (q_pop && q_req.action == ACT_TICK)
                    begin
                        tick_reg <= tick_inc;
                    end
                end
                ST_REMOVE:
                begin
                    // shift left past the removed slot
                    if (pos_reg >= len_reg || !queued_reg[slot_i])
                    begin
                        if (queued_reg[slot_i])
                        begin
                            len_reg <= len_reg - 1'b1;
                        end
                        queued_reg[slot_i] <= 1'b0;
                        pos_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        if (found_reg || ord_reg[pos_reg[SB-1:0]] == slot_i)
                        begin
                            if (32'(pos_reg) + 1 < ALARM_SLOTS)
                            begin
                                ord_reg[pos_reg[SB-1:0]] <= ord_reg[SB'(pos_reg + 1'b1)];
                            end
                            found_reg <= 1'b1;
                        end
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                ST_INSERT:
                begin
                    if (pos_reg >= len_reg || dl_reg[ord_reg[pos_reg[SB-1:0]]] > cdl)
                    begin
                        for (int i = 1; i < ALARM_SLOTS; i++)
                        begin
                            if (LB'(i) > pos_reg && LB'(i) <= len_reg)
                            begin
                                ord_reg[i] <= ord_reg[i-1];
                            end
                        end
                        ord_reg[pos_reg[SB-1:0]] <= slot_i;
                        queued_reg[slot_i] <= 1'b1;
                        len_reg <= len_reg + 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                ST_FIRE:
                begin
                    if (out_free)
                    begin
                        ov_reg <= 1'b1;
                        ot_reg <= 32'(tick_reg);
                        if (len_reg != '0 && dl_reg[head] <= tick_reg)
                        begin
                            // pop the head
                            for (int i = 0; i + 1 < ALARM_SLOTS; i++)
                            begin
                                ord_reg[i] <= ord_reg[i+1];
                            end
                            queued_reg[head] <= 1'b0;
                            len_reg   <= len_reg - 1'b1;
                            fired_reg <= 1'b1;
                            ok_reg <= KIND_FIRED;
                            os_reg <= 4'(head);
                            or_reg <= 1'b0;
                            ol_reg <= 1'b0;
                        end
                        else
                        begin
                            ok_reg <= KIND_TICK;
                            os_reg <= '0;
                            or_reg <= fired_reg;
                            ol_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg <= 1'b1;
                        ok_reg <= KIND_ACK;
                        os_reg <= '0;
                        ot_reg <= 32'(tick_reg);
                        or_reg <= 1'b0;
                        ol_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ hdl/sorted_alarm_queue_timer_top.sv @@
// Sorted alarm queue timer: top level, front, queue and engine.
// Depends on saqt_pkg, saqt_front, saqt_fifo, saqt_engine and the macros header.
//
// Usage: requests enter on valid_in/stall_in with action, alarm_slot and
// deadline. Tick advances the counter and fires every queued alarm whose
// deadline is not later than the new tick, in deadline order, one result
// per fired alarm, then a tick-finished result with last set. Set and
// cancel give one acknowledge result. Results leave on valid_out/stall_out.
// Path: a request is registered in the front, then in the queue and then
// in the engine's dispatch. Set walks the ordered list twice, one
// position a cycle (remove, then insert); a tick fires its alarms one at
// a time, each result held while the output stalls.
// The list walk in the engine sets the rate.
// Reset empties the list and loads tick zero; writing tick_start does the
// same with the written value. A stall holds the result register; the
// front and its two-entry queue keep taking requests until full.
`include "sorted_alarm_queue_timer_top_macros.svh"
module sorted_alarm_queue_timer_top
    import saqt_pkg::*;
#(
    parameter int ALARM_SLOTS = 16,
    parameter int TICK_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [1:0]  action,
    input  logic [3:0]  alarm_slot,
    input  logic [31:0] deadline,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [1:0]  result_kind,
    output logic [3:0]  fired_slot,
    output logic [31:0] tick_value,
    output logic        reschedule,
    output logic        last
);
    logic      f_valid, f_stall, e_valid, e_pop;
    saqt_req_t f_req, e_req;
    logic [TICK_BITS-1:0] cfg_tick;

    // take the low tick bits of the start value
    assign cfg_tick = TICK_BITS'(cfg_wdata);

    saqt_front #(.ALARM_SLOTS(ALARM_SLOTS), .TICK_BITS(TICK_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .valid_in(valid_in), .stall_in(stall_in),
        .action(action), .alarm_slot(alarm_slot), .deadline(deadline),
        .q_valid(f_valid), .q_stall(f_stall), .q_req(f_req)
    );

    saqt_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_stall(f_stall),
        .in_req(f_req), .out_valid(e_valid), .out_pop(e_pop), .out_req(e_req)
    );

    saqt_engine #(.ALARM_SLOTS(ALARM_SLOTS), .TICK_BITS(TICK_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_tick(cfg_tick),
        .q_valid(e_valid), .q_pop(e_pop), .q_req(e_req),
        .valid_out(valid_out), .stall_out(stall_out), .result_kind(result_kind),
        .fired_slot(fired_slot), .tick_value(tick_value),
        .reschedule(reschedule), .last(last)
    );

    `SAQ_ASSERT_IMPL(a_fire_not_last, valid_out && result_kind == KIND_FIRED, !last,
        "fired result marked last")
    `SAQ_ASSERT_IMPL(a_ack_clean, valid_out && result_kind == KIND_ACK,
        last && !reschedule && fired_slot == 4'd0, "acknowledge fields wrong")
    `SAQ_ASSERT_NEXT(a_hold, valid_out && stall_out,
        valid_out && $stable(result_kind) && $stable(fired_slot) && $stable(tick_value),
        "stalled result changed")
endmodule

@@ tb/tb.sv @@
// Testbench for sorted_alarm_queue_timer_top: directed and random requests with a
// self-contained scoreboard that predicts the ordered alarm list and tick counter.
// Depends on saqt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb
    import saqt_pkg::*;
();

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] tick;
        logic        resched;
        logic        fin;
    } alarm_result_t;

    // Scoreboard: mirrors the timer state and holds the results still due.
    class alarm_scoreboard;
        logic [31:0]   tick_now;
        logic [31:0]   due_tick [16];
        bit            armed [16];
        logic [3:0]    order [16];
        int            depth;
        alarm_result_t pending [$];
        int            errors;

        function void init(logic [31:0] start);
            tick_now = start;
            depth = 0;
            foreach (armed[i]) armed[i] = 0;
        endfunction

        function void unlink(int s);
            int i;
            int j;
            if (!armed[s])
                return;
            for (i = 0; i < depth; i++)
            begin
                if (order[i] == s)
                begin
                    for (j = i; j + 1 < depth; j++)
                        order[j] = order[j + 1];
                    depth--;
                    break;
                end
            end
            armed[s] = 0;
        endfunction

        function void link(int s, logic [31:0] dl);
            int pos;
            int j;
            pos = 0;
            while (pos < depth && due_tick[order[pos]] <= dl)
                pos++;
            for (j = depth; j > pos; j--)
                order[j] = order[j - 1];
            order[pos] = s;
            due_tick[s] = dl;
            armed[s] = 1;
            depth++;
        endfunction

        function void note_request(logic [1:0] act, logic [3:0] s, logic [31:0] dl);
            alarm_result_t r;
            bit any;
            int head;
            any = 0;
            if (act == ACT_TICK)
            begin
                tick_now++;
                while (depth > 0 && due_tick[order[0]] <= tick_now)
                begin
                    head = order[0];
                    unlink(head);
                    r = '{KIND_FIRED, head[3:0], tick_now, 1'b0, 1'b0};
                    pending.push_back(r);
                    any = 1;
                end
                r = '{KIND_TICK, 4'd0, tick_now, any, 1'b1};
            end
            else
            begin
                if (act == ACT_SET || act == ACT_CANCEL)
                begin
                    unlink(s);
                    if (act == ACT_SET && dl != 0)
                        link(s, dl);
                end
                r = '{KIND_ACK, 4'd0, tick_now, 1'b0, 1'b1};
            end
            pending.push_back(r);
        endfunction

        function void check_result(alarm_result_t got);
            alarm_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d slot %0d", $time, got.kind, got.slot);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (exp.kind !== got.kind)
                $display("%0t: kind exp %0d act %0d", $time, exp.kind, got.kind);
            if (exp.slot !== got.slot)
                $display("%0t: slot exp %0d act %0d", $time, exp.slot, got.slot);
            if (exp.tick !== got.tick)
                $display("%0t: tick exp %0h act %0h", $time, exp.tick, got.tick);
            if (exp.resched !== got.resched)
                $display("%0t: reschedule exp %0b act %0b", $time, exp.resched, got.resched);
            if (exp.fin !== got.fin)
                $display("%0t: last exp %0b act %0b", $time, exp.fin, got.fin);
            if (exp.kind !== got.kind || exp.slot !== got.slot || exp.tick !== got.tick
                || exp.resched !== got.resched || exp.fin !== got.fin)
                errors++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        valid_in = 0;
    logic        stall_in;
    logic [1:0]  action = 0;
    logic [3:0]  alarm_slot = 0;
    logic [31:0] deadline = 0;
    logic        valid_out;
    logic        stall_out = 0;
    logic [1:0]  result_kind;
    logic [3:0]  fired_slot;
    logic [31:0] tick_value;
    logic        reschedule;
    logic        last;

    alarm_scoreboard sb = new();
    bit  quiet = 0;       // last part of the run: no idling on either side
    int  cycles = 0;
    localparam int CYCLE_LIMIT = 400000;

    sorted_alarm_queue_timer_top dut (.*);

    always #5 clk = ~clk;

    // Count cycles and give up at a generous limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check every accepted result, stall in random bursts.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (valid_out && !stall_out)
            sb.check_result('{result_kind, fired_slot, tick_value, reschedule, last});
        if (stall_left > 0)
        begin
            stall_left--;
            stall_out <= 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            stall_out <= 1;
        end
        else
            stall_out <= 0;
    end

    // Write tick_start while idle; the block reinitialises its list.
    task automatic write_tick_start(logic [31:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.init(v);
        @(posedge clk);
    endtask

    // Present one request and hold it until accepted, with an optional gap first.
    // Valid stays high after acceptance unless a gap or a drain follows.
    task automatic send_request(logic [1:0] act, logic [3:0] s, logic [31:0] dl);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            valid_in <= 0;
            repeat (gap) @(posedge clk);
        end
        valid_in   <= 1;
        action     <= act;
        alarm_slot <= s;
        deadline   <= dl;
        @(posedge clk);
        while (stall_in)
            @(posedge clk);
        sb.note_request(act, s, dl);
    endtask

    // Hold until every expected result has arrived, then let the engine settle.
    task automatic drain;
        valid_in <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Mostly near deadlines so that ticks fire alarms; some far or zero.
    function automatic logic [31:0] pick_deadline();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return sb.tick_now + $urandom_range(0, 6) - 1;
        if (r == 7)
            return 32'd0;
        return $urandom;
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_request(ACT_TICK, 4'($urandom), $urandom);
            else if (r < 8)
                send_request(ACT_SET, 4'($urandom), pick_deadline());
            else if (r < 9)
                send_request(ACT_CANCEL, 4'($urandom), $urandom);
            else
                send_request(ACT_NONE, 4'($urandom), $urandom);
        end
    endtask

    initial
    begin
        sb.errors = 0;
        sb.init(0);
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: equal deadlines keep insertion order, re-set, cancel,
        // zero deadline, unused action code, all-ones fields.
        send_request(ACT_SET, 4'd3, 32'd2);
        send_request(ACT_SET, 4'd15, 32'd2);
        send_request(ACT_SET, 4'd0, 32'd1);
        send_request(ACT_SET, 4'd7, 32'd5);
        send_request(ACT_SET, 4'd7, 32'd3);
        send_request(ACT_SET, 4'd9, 32'd4);
        send_request(ACT_CANCEL, 4'd9, 32'hFFFF_FFFF);
        send_request(ACT_SET, 4'd10, 32'd0);
        send_request(ACT_SET, 4'd11, 32'hFFFF_FFFF);
        send_request(ACT_NONE, 4'd11, 32'hFFFF_FFFF);
        send_request(ACT_TICK, 4'd0, 32'd0);
        send_request(ACT_TICK, 4'd15, 32'hFFFF_FFFF);
        send_request(ACT_TICK, 4'd0, 32'd0);
        for (int s = 0; s < 16; s++)
            send_request(ACT_SET, s[3:0], 32'd5);
        send_request(ACT_TICK, 4'd0, 32'd0);
        drain();

        // Tick wraps from all ones to zero.
        write_tick_start(32'hFFFF_FFFE);
        send_request(ACT_SET, 4'd1, 32'hFFFF_FFFF);
        send_request(ACT_TICK, 4'd0, 32'd0);
        send_request(ACT_TICK, 4'd0, 32'd0);
        random_phase(60);
        drain();

        write_tick_start(32'd0);
        random_phase(100);
        // Sender waits for every result before going on.
        drain();

        write_tick_start($urandom);
        random_phase(100);
        drain();

        quiet = 1;
        random_phase(40);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
